// ----- design/itc_pkg.sv -----
`default_nettype none

package itc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_TURN_SECONDS     = 2'd1;
  localparam logic [1:0] CFG_DAY_LIMIT        = 2'd2;
  localparam logic [1:0] CFG_HEATER_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [11:0] TICKS_PER_SECOND_RST = 12'd3906;
  localparam logic [5:0]  TURN_SECONDS_RST     = 6'd28;
  localparam logic [7:0]  DAY_LIMIT_RST        = 8'd14;
  localparam logic [9:0]  HEATER_THRESHOLD_RST = 10'd37;

  // input commands
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // time count limits
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;
  localparam logic [7:0] DAY_MAX   = 8'd255;

  // converter scaling, q16: deg = (code * gain - offset) >> 16
  localparam logic [16:0] TEMP_GAIN_Q16   = 17'd80078;
  localparam logic [26:0] TEMP_OFFSET_Q16 = 27'd15483378;

  localparam int CFG_DATA_W = 12;

  typedef struct packed {
    logic       cmd;
    logic [9:0] adc_code;
  } itc_in_t;

  typedef struct packed {
    logic [9:0] temp_deg;
    logic       heater_on;
    logic       motor_on;
    logic [5:0] seconds_now;
    logic [5:0] minutes_now;
    logic [4:0] hours_now;
    logic [7:0] days_now;
    logic       period_done;
  } itc_out_t;

  typedef struct packed {
    logic [11:0] ticks_per_second;
    logic [5:0]  turn_seconds;
    logic [7:0]  day_limit;
    logic [9:0]  heater_threshold;
  } itc_cfg_t;

  // time of day and period status
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [7:0] day;
    logic       done;
  } itc_tod_t;

  // one item leaving the input register
  typedef struct packed {
    logic    go;
    itc_in_t item;
  } itc_step_t;

endpackage

`default_nettype wire

// ----- design/itc_cfg_regs.sv -----
`default_nettype none

module itc_cfg_regs
  import itc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output itc_cfg_t                   cfg
);

  itc_cfg_t cfg_r;
  itc_cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: cfg_nxt.ticks_per_second = cfg_wdata;
        CFG_TURN_SECONDS:     cfg_nxt.turn_seconds     = cfg_wdata[5:0];
        CFG_DAY_LIMIT:        cfg_nxt.day_limit        = cfg_wdata[7:0];
        CFG_HEATER_THRESHOLD: cfg_nxt.heater_threshold = cfg_wdata[9:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_second <= TICKS_PER_SECOND_RST;
      cfg_r.turn_seconds     <= TURN_SECONDS_RST;
      cfg_r.day_limit        <= DAY_LIMIT_RST;
      cfg_r.heater_threshold <= HEATER_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/itc_timebase.sv -----
`default_nettype none

module itc_timebase
  import itc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire itc_step_t step,
  input  wire itc_cfg_t  cfg,
  output itc_tod_t       tod,
  output itc_tod_t       tod_next
);

  logic [11:0] tick_r;
  logic [11:0] tick_nxt;
  itc_tod_t    tod_r;
  itc_tod_t    tod_nxt;

  logic [12:0] tick_inc;
  logic        sec_tick;
  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;
  logic [7:0]  day_inc;

  assign tick_inc  = {1'b0, tick_r} + 13'd1;
  // zero limit behaves like one: every tick completes a second
  assign sec_tick  = step.go && (step.item.cmd == CMD_TICK) &&
                     (tick_inc >= {1'b0, cfg.ticks_per_second});
  assign sec_wrap  = (tod_r.sec == SEC_LAST);
  assign min_wrap  = sec_wrap && (tod_r.min == MIN_LAST);
  assign hour_wrap = min_wrap && (tod_r.hour == HOUR_LAST);
  assign day_inc   = tod_r.day + 8'd1;

  // prescaler and cascaded counters
  always_comb begin
    tick_nxt = tick_r;
    tod_nxt  = tod_r;
    if (step.go && (step.item.cmd == CMD_TICK)) begin
      tick_nxt = sec_tick ? 12'd0 : tick_inc[11:0];
    end
    if (sec_tick) begin
      tod_nxt.sec = sec_wrap ? 6'd0 : tod_r.sec + 6'd1;
      if (sec_wrap) begin
        tod_nxt.min = min_wrap ? 6'd0 : tod_r.min + 6'd1;
      end
      if (min_wrap) begin
        tod_nxt.hour = hour_wrap ? 5'd0 : tod_r.hour + 5'd1;
      end
      // days saturate, done latches on reaching the limit
      if (hour_wrap && (tod_r.day != DAY_MAX)) begin
        tod_nxt.day = day_inc;
        if (day_inc == cfg.day_limit) begin
          tod_nxt.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      tod_r  <= '0;
    end else begin
      tick_r <= tick_nxt;
      tod_r  <= tod_nxt;
    end
  end

  assign tod      = tod_r;
  assign tod_next = tod_nxt;

  // the done latch never drops outside reset
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tod_r.done |=> tod_r.done)
    else $error("period done flag cleared");

  // time only moves on a tick beat
  a_time_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !(step.go && (step.item.cmd == CMD_TICK)) |=> $stable(tod_r))
    else $error("time counts moved without a tick");

endmodule

`default_nettype wire

// ----- design/itc_climate.sv -----
`default_nettype none

module itc_climate
  import itc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire itc_step_t step,
  input  wire itc_cfg_t  cfg,
  input  wire itc_tod_t  tod,
  output logic [9:0]     temp_next,
  output logic           heater_next,
  output logic           motor_next
);

  logic [9:0]  temp_r;
  logic [9:0]  temp_nxt;
  logic        heater_r;
  logic        heater_nxt;
  logic        motor_r;
  logic        motor_nxt;

  logic        sample;
  logic [26:0] prod;
  logic [26:0] diff;
  logic        above_zero;
  logic [9:0]  conv;

  assign sample = step.go && (step.item.cmd == CMD_SAMPLE);

  // q16 conversion, negative results clamp to zero
  assign prod       = 27'(step.item.adc_code) * 27'(TEMP_GAIN_Q16);
  assign above_zero = (prod >= TEMP_OFFSET_Q16);
  assign diff       = prod - TEMP_OFFSET_Q16;
  assign conv       = above_zero ? diff[25:16] : 10'd0;

  // heater and turning motor decisions on a sample
  always_comb begin
    temp_nxt   = temp_r;
    heater_nxt = heater_r;
    motor_nxt  = motor_r;
    if (sample) begin
      temp_nxt   = conv;
      heater_nxt = (conv < cfg.heater_threshold);
      motor_nxt  = !tod.done && (tod.min == 6'd0) && (tod.sec < cfg.turn_seconds);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_r   <= '0;
      heater_r <= 1'b0;
      motor_r  <= 1'b0;
    end else begin
      temp_r   <= temp_nxt;
      heater_r <= heater_nxt;
      motor_r  <= motor_nxt;
    end
  end

  assign temp_next   = temp_nxt;
  assign heater_next = heater_nxt;
  assign motor_next  = motor_nxt;

  // climate outputs hold between samples
  a_hold_between_samples: assert property (@(posedge clk) disable iff (!rst_n)
    !sample |=> $stable(temp_r) && $stable(heater_r) && $stable(motor_r))
    else $error("climate state changed without a sample");

endmodule

`default_nettype wire

// ----- design/incubator_timekeeper_controller_core.sv -----
// channel | direction | handshake          | payload
// in_     | input     | in_valid / in_stall   | itc_in_t  (cmd, adc_code)
// out_    | output    | out_valid / out_stall | itc_out_t (temp, heater, motor, time, done)
// cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// one result beat per input beat, carried by the input register and then the result register
// a new beat is taken every cycle unless a stalled result blocks it; the input register
// feeds one stage of counter and converter logic that writes the result register
// reset is synchronous, active low, and restores all counts, config and valid flags;
// payload registers are not reset; a stalled result holds; the input register keeps
// taking a beat while its own beat can move into the result register

`default_nettype none

module incubator_timekeeper_controller_core
  import itc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire itc_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output itc_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  itc_in_t   s1_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  itc_out_t  out_data_r;
  itc_out_t  out_data_nxt;

  logic      in_take;
  logic      s1_advance;
  itc_step_t step;
  itc_cfg_t  cfg;
  itc_tod_t  tod;
  itc_tod_t  tod_next;
  logic [9:0] temp_next;
  logic      heater_next;
  logic      motor_next;

  // handshake control
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  assign step.go   = s1_advance;
  assign step.item = s1_data_r;

  itc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  itc_timebase u_timebase (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cfg      (cfg),
    .tod      (tod),
    .tod_next (tod_next)
  );

  itc_climate u_climate (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .cfg         (cfg),
    .tod         (tod),
    .temp_next   (temp_next),
    .heater_next (heater_next),
    .motor_next  (motor_next)
  );

  // result beat reflects state after the item
  always_comb begin
    out_data_nxt.temp_deg    = temp_next;
    out_data_nxt.heater_on   = heater_next;
    out_data_nxt.motor_on    = motor_next;
    out_data_nxt.seconds_now = tod_next.sec;
    out_data_nxt.minutes_now = tod_next.min;
    out_data_nxt.hours_now   = tod_next.hour;
    out_data_nxt.days_now    = tod_next.day;
    out_data_nxt.period_done = tod_next.done;
  end

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_advance ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted beat always lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> s1_valid_r)
    else $error("accepted beat lost at input register");

  // a blocked input register keeps its beat
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register changed while blocked");

  // a beat only moves on when the result register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
